>>> rtl/tklek_pkg.sv
// Shared types and constants for the top-k largest extent keeper.
package tklek_pkg;

	// field widths fixed by the request and result formats
	localparam int DEV_W      = 4;
	localparam int SECT_W     = 48;
	localparam int SLOT_W     = 10;
	localparam int KEPT_W     = 11;
	localparam int FREE_EXT_W = 32;
	localparam int CAP_W      = 11;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SLOT   = 2'd1;
	localparam logic [1:0] REQ_STAT   = 2'd2;

	// register indexes (paddr bit 2)
	localparam logic REG_MIN_EXTENT = 1'b0;
	localparam logic REG_CAPACITY   = 1'b1;

	// register reset values
	localparam logic [APB_DW-1:0] MIN_EXTENT_RST = 32'd8192;
	localparam logic [CAP_W-1:0]  CAPACITY_RST   = 11'd1024;

	// one kept extent
	typedef struct packed {
		logic [DEV_W-1:0]  dev;
		logic [SECT_W-1:0] start;
		logic [SECT_W-1:0] len;
	} slot_entry_t;

	// per-device counters
	typedef struct packed {
		logic [FREE_EXT_W-1:0] free_ext;
		logic [SECT_W-1:0]     free_sec;
		logic [KEPT_W-1:0]     kept_ext;
		logic [SECT_W-1:0]     kept_sec;
	} dev_ctr_t;

endpackage

>>> rtl/top_k_largest_extent_keeper.sv
// Top-k largest extent keeper: min-heap store of the longest extents plus device counters.
// An insert is dropped when shorter than the minimum, or when the store is full and it is not
// longer than the root; else it is appended, or replaces the root and sifts down.
// The insert that fills the store also builds the heap, sifting down each inner node.
// One request at a time; the next is taken in the done cycle. Results are never stalled.
// Reset clears the counters (via per-device valid bits), fill count and registers; not slots.
module top_k_largest_extent_keeper
	import tklek_pkg::*;
#(
	parameter int SLOTS   = 1024,
	parameter int DEVICES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              req_type,
	input  logic [DEV_W-1:0]        device,
	input  logic [SECT_W-1:0]       start_sector,
	input  logic [SECT_W-1:0]       sector_count,
	input  logic [SLOT_W-1:0]       slot,
	// result
	output logic                    done,
	output logic                    accepted,
	output logic                    evicted,
	output logic [DEV_W-1:0]        entry_device,
	output logic [SECT_W-1:0]       entry_start,
	output logic [SECT_W-1:0]       entry_count,
	output logic [KEPT_W-1:0]       kept_count,
	output logic [FREE_EXT_W-1:0]   stat_free_extents,
	output logic [SECT_W-1:0]       stat_free_sectors,
	output logic [KEPT_W-1:0]       stat_accepted_extents,
	output logic [SECT_W-1:0]       stat_accepted_sectors,
	// configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [APB_AW-1:0]       paddr,
	input  logic [APB_DW-1:0]       pwdata,
	output logic [APB_DW-1:0]       prdata,
	output logic                    pready
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_FREE_RD,
		S_FREE_WR,
		S_APPEND,
		S_HEAP_RD,
		S_HEAP_LD,
		S_ROOT_RD,
		S_ROOT_CMP,
		S_KSUB_RD,
		S_KSUB_WR,
		S_SIFT_RD,
		S_SIFT_CMP,
		S_KADD_RD,
		S_KADD_WR,
		S_SLOT_RD,
		S_SLOT_RES,
		S_STAT_RD,
		S_STAT_RES,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [APB_DW-1:0] min_q;
	logic [CAP_W-1:0]  cap_q;

	// latched request
	logic [1:0]        in_req_q;
	logic [DEV_W-1:0]  in_dev_q;
	logic [SECT_W-1:0] in_start_q;
	logic [SECT_W-1:0] in_len_q;
	logic [SLOT_W-1:0] in_slot_q;

	// heap control
	logic [CW-1:0]     used_q;
	logic [CW-1:0]     hn_q;
	logic [SW-1:0]     node_q;
	logic              heap_mode_q;
	slot_entry_t       cur_q;

	// result registers
	logic              done_q;
	logic              res_acc_q;
	logic              res_evict_q;
	slot_entry_t       res_entry_q;
	logic [KEPT_W-1:0] res_kept_q;
	dev_ctr_t          res_stat_q;

	// slot store
	slot_entry_t       slot_mem [SLOTS];
	slot_entry_t       rd_a_q;
	slot_entry_t       rd_b_q;
	logic [SW-1:0]     addr_a_c;
	logic [SW-1:0]     addr_b_c;
	logic              slot_we_c;
	logic [SW-1:0]     slot_waddr_c;
	slot_entry_t       slot_wdata_c;

	// device counter store
	dev_ctr_t          dev_mem [DEVICES];
	logic              dev_valid_q [DEVICES];
	dev_ctr_t          dev_rd_q;
	logic              dev_rv_q;
	dev_ctr_t          dev_cur_c;
	dev_ctr_t          dev_wdata_c;
	logic              dev_we_c;
	logic [DEV_W-1:0]  dev_sel_c;
	logic [31:0]       dev_wide_c;
	logic [DW-1:0]     dev_addr_c;
	logic              dev_ok_c;

	// derived values
	logic [CW-1:0]     cap_eff_c;
	logic [CW-1:0]     used_inc_c;
	logic [CW-1:0]     half_c;
	logic [SW+1:0]     l_idx_c;
	logic [SW+1:0]     r_idx_c;
	logic [SW+1:0]     used_ext_c;
	logic              l_ok_c;
	logic              r_ok_c;
	logic              lt_l_c;
	logic              lt_r_c;
	logic [SECT_W-1:0] min_len_c;
	logic [31:0]       slot_wide_c;
	logic              slot_ok_c;
	logic              keep_c;
	logic [SECT_W:0]   free_sum_c;
	logic [SECT_W:0]   kept_sum_c;

	assign busy  = (state_q != S_IDLE);
	assign pready = 1'b1;

	// result ports
	assign done                  = done_q;
	assign accepted              = res_acc_q;
	assign evicted               = res_evict_q;
	assign entry_device          = res_entry_q.dev;
	assign entry_start           = res_entry_q.start;
	assign entry_count           = res_entry_q.len;
	assign kept_count            = res_kept_q;
	assign stat_free_extents     = res_stat_q.free_ext;
	assign stat_free_sectors     = res_stat_q.free_sec;
	assign stat_accepted_extents = res_stat_q.kept_ext;
	assign stat_accepted_sectors = res_stat_q.kept_sec;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_EXTENT_RST;
			cap_q <= CAPACITY_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_MIN_EXTENT: min_q <= pwdata;
				REG_CAPACITY:   cap_q <= pwdata[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// configuration reads
	always_comb begin
		case (paddr[2])
			REG_MIN_EXTENT: prdata = min_q;
			REG_CAPACITY:   prdata = {{(APB_DW-CAP_W){1'b0}}, cap_q};
			default:        prdata = '0;
		endcase
	end

	// capacity limited to 1..SLOTS
	always_comb begin
		if (cap_q == '0)
			cap_eff_c = CW'(1);
		else if (32'(cap_q) > SLOTS)
			cap_eff_c = CW'(SLOTS);
		else
			cap_eff_c = CW'(cap_q);
	end

	assign used_inc_c = used_q + CW'(1);
	assign half_c     = used_inc_c >> 1;
	assign keep_c     = (in_len_q >= {{(SECT_W-APB_DW){1'b0}}, min_q});

	// heap children of the current node
	assign l_idx_c    = {1'b0, node_q, 1'b1};
	assign r_idx_c    = l_idx_c + (SW+2)'(1);
	assign used_ext_c = {{(SW+2-CW){1'b0}}, used_q};
	assign l_ok_c     = (l_idx_c < used_ext_c);
	assign r_ok_c     = (r_idx_c < used_ext_c);

	// smallest of node, left and right by length
	assign lt_l_c    = l_ok_c && (rd_a_q.len < cur_q.len);
	assign min_len_c = lt_l_c ? rd_a_q.len : cur_q.len;
	assign lt_r_c    = r_ok_c && (rd_b_q.len < min_len_c);

	// slot read range check
	assign slot_wide_c = 32'(in_slot_q);
	assign slot_ok_c   = (slot_wide_c < SLOTS) && (slot_wide_c < 32'(used_q));

	// slot store ports
	always_comb begin
		case (state_q)
			S_ROOT_RD: addr_a_c = '0;
			S_SLOT_RD: addr_a_c = slot_wide_c[SW-1:0];
			S_HEAP_RD: addr_a_c = hn_q[SW-1:0];
			default:   addr_a_c = l_idx_c[SW-1:0];
		endcase
		addr_b_c = r_idx_c[SW-1:0];

		slot_we_c    = 1'b0;
		slot_waddr_c = node_q;
		slot_wdata_c = cur_q;
		if (state_q == S_APPEND) begin
			slot_we_c    = 1'b1;
			slot_waddr_c = used_q[SW-1:0];
			slot_wdata_c = '{dev: in_dev_q, start: in_start_q, len: in_len_q};
		end else if (state_q == S_SIFT_CMP) begin
			slot_we_c = 1'b1;
			if (lt_r_c)
				slot_wdata_c = rd_b_q;
			else if (lt_l_c)
				slot_wdata_c = rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we_c)
			slot_mem[slot_waddr_c] <= slot_wdata_c;
		rd_a_q <= slot_mem[addr_a_c];
		rd_b_q <= slot_mem[addr_b_c];
	end

	// device counter address: evicted device during the decrement, else request device
	assign dev_sel_c  = (state_q == S_KSUB_RD || state_q == S_KSUB_WR) ?
	                    res_entry_q.dev : in_dev_q;
	assign dev_wide_c = 32'(dev_sel_c);
	assign dev_addr_c = dev_wide_c[DW-1:0];
	assign dev_ok_c   = (dev_wide_c < DEVICES);
	assign dev_cur_c  = dev_rv_q ? dev_rd_q : '0;

	// saturating counter updates
	assign free_sum_c = {1'b0, dev_cur_c.free_sec} + {1'b0, in_len_q};
	assign kept_sum_c = {1'b0, dev_cur_c.kept_sec} + {1'b0, in_len_q};

	always_comb begin
		dev_wdata_c = dev_cur_c;
		dev_we_c    = 1'b0;
		case (state_q)
			S_FREE_WR: begin
				dev_we_c = dev_ok_c;
				if (!(&dev_cur_c.free_ext))
					dev_wdata_c.free_ext = dev_cur_c.free_ext + FREE_EXT_W'(1);
				dev_wdata_c.free_sec = free_sum_c[SECT_W] ? '1 : free_sum_c[SECT_W-1:0];
			end
			S_KADD_WR: begin
				dev_we_c = dev_ok_c;
				if (!(&dev_cur_c.kept_ext))
					dev_wdata_c.kept_ext = dev_cur_c.kept_ext + KEPT_W'(1);
				dev_wdata_c.kept_sec = kept_sum_c[SECT_W] ? '1 : kept_sum_c[SECT_W-1:0];
			end
			S_KSUB_WR: begin
				dev_we_c = dev_ok_c;
				if (dev_cur_c.kept_ext != '0)
					dev_wdata_c.kept_ext = dev_cur_c.kept_ext - KEPT_W'(1);
				dev_wdata_c.kept_sec = (dev_cur_c.kept_sec > res_entry_q.len) ?
				                       dev_cur_c.kept_sec - res_entry_q.len : '0;
			end
			default: ;
		endcase
	end

	// device counter store; entries not yet written read as zero
	always_ff @(posedge clk) begin
		if (dev_we_c)
			dev_mem[dev_addr_c] <= dev_wdata_c;
		dev_rd_q <= dev_mem[dev_addr_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEVICES; i++)
				dev_valid_q[i] <= 1'b0;
			dev_rv_q <= 1'b0;
		end else begin
			if (dev_we_c)
				dev_valid_q[dev_addr_c] <= 1'b1;
			dev_rv_q <= dev_ok_c && dev_valid_q[dev_addr_c];
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			hn_q        <= '0;
			node_q      <= '0;
			heap_mode_q <= 1'b0;
			cur_q       <= '0;
			in_req_q    <= '0;
			in_dev_q    <= '0;
			in_start_q  <= '0;
			in_len_q    <= '0;
			in_slot_q   <= '0;
			done_q      <= 1'b0;
			res_acc_q   <= 1'b0;
			res_evict_q <= 1'b0;
			res_entry_q <= '0;
			res_kept_q  <= '0;
			res_stat_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						in_req_q    <= req_type;
						in_dev_q    <= device;
						in_start_q  <= start_sector;
						in_len_q    <= sector_count;
						in_slot_q   <= slot;
						res_acc_q   <= 1'b0;
						res_evict_q <= 1'b0;
						res_entry_q <= '0;
						res_stat_q  <= '0;
						case (req_type)
							REQ_INSERT: state_q <= S_FREE_RD;
							REQ_SLOT:   state_q <= S_SLOT_RD;
							REQ_STAT:   state_q <= S_STAT_RD;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_FREE_RD: state_q <= S_FREE_WR;
				S_FREE_WR: begin
					if (!keep_c)
						state_q <= S_DONE;
					else if (used_q < cap_eff_c)
						state_q <= S_APPEND;
					else
						state_q <= S_ROOT_RD;
				end
				S_APPEND: begin
					used_q    <= used_inc_c;
					res_acc_q <= 1'b1;
					if (used_inc_c == cap_eff_c && half_c != '0) begin
						hn_q        <= half_c - CW'(1);
						heap_mode_q <= 1'b1;
						state_q     <= S_HEAP_RD;
					end else begin
						state_q <= S_KADD_RD;
					end
				end
				S_HEAP_RD: state_q <= S_HEAP_LD;
				S_HEAP_LD: begin
					cur_q   <= rd_a_q;
					node_q  <= hn_q[SW-1:0];
					state_q <= S_SIFT_RD;
				end
				S_ROOT_RD: state_q <= S_ROOT_CMP;
				S_ROOT_CMP: begin
					if (rd_a_q.len < in_len_q) begin
						res_acc_q   <= 1'b1;
						res_evict_q <= 1'b1;
						res_entry_q <= rd_a_q;
						cur_q       <= '{dev: in_dev_q, start: in_start_q, len: in_len_q};
						node_q      <= '0;
						heap_mode_q <= 1'b0;
						state_q     <= S_KSUB_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_KSUB_RD: state_q <= S_KSUB_WR;
				S_KSUB_WR: state_q <= S_SIFT_RD;
				S_SIFT_RD: state_q <= S_SIFT_CMP;
				S_SIFT_CMP: begin
					// move the smaller child up, or settle the held entry here
					if (lt_r_c) begin
						node_q  <= r_idx_c[SW-1:0];
						state_q <= S_SIFT_RD;
					end else if (lt_l_c) begin
						node_q  <= l_idx_c[SW-1:0];
						state_q <= S_SIFT_RD;
					end else if (heap_mode_q && hn_q != '0) begin
						hn_q    <= hn_q - CW'(1);
						state_q <= S_HEAP_RD;
					end else begin
						state_q <= S_KADD_RD;
					end
				end
				S_KADD_RD: state_q <= S_KADD_WR;
				S_KADD_WR: state_q <= S_DONE;
				S_SLOT_RD: state_q <= S_SLOT_RES;
				S_SLOT_RES: begin
					if (slot_ok_c)
						res_entry_q <= rd_a_q;
					state_q <= S_DONE;
				end
				S_STAT_RD: state_q <= S_STAT_RES;
				S_STAT_RES: begin
					if (dev_ok_c)
						res_stat_q <= dev_cur_c;
					state_q <= S_DONE;
				end
				S_DONE: begin
					res_kept_q <= KEPT_W'(used_q);
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE) && $past(state_q == S_DONE))
		else $error("result strobe outside the end of a request");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= SLOTS)
		else $error("fill count beyond store depth");

	a_evict_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_evict_q) |-> res_acc_q && (in_req_q == REQ_INSERT))
		else $error("eviction reported without a kept insert");

endmodule
